>>> src/btmx_pkg.sv
package btmx_pkg;

   localparam int KEY_BITS = 31;
   localparam int LVL_W    = $clog2(KEY_BITS);
   localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(KEY_BITS - 1);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [KEY_BITS-1:0] key;
   } req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] max_xor;
      logic                no_entries;
      logic                rejected;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FILL,
      S_DONE
   } state_type;

endpackage

>>> src/btmx_rsp_stage.sv
module btmx_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  btmx_pkg::rsp_type load_data,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output btmx_pkg::rsp_type rsp_data
);
   import btmx_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // slot frees up in the same cycle the held word is taken
   assign can_load  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

>>> src/binary_trie_max_xor_core.sv
// A rejected insert or a query on an empty trie goes straight to S_DONE; any
// other word first walks all KEY_BITS levels of the trie.
// A new word is taken only in S_IDLE, after the last result is loaded; the walk
// reads one node per cycle from the single-port child table, root held in flops.
// Reset: node pool back to the root alone, trie empty; the table is not swept.
module binary_trie_max_xor_core #(
   parameter int NODE_COUNT = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  btmx_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output btmx_pkg::rsp_type rsp_data
);
   import btmx_pkg::*;

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int CNT_W  = $clog2(NODE_COUNT + 1);
   localparam logic [CNT_W-1:0] USED_LIMIT = CNT_W'(NODE_COUNT - KEY_BITS);

   typedef logic [1:0][NODE_W-1:0] entry_type;

   entry_type mem [NODE_COUNT];

   state_type           state_ff, state_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                kind_ff, kind_in;
   logic [KEY_BITS-1:0] ans_ff, ans_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic                has_ff, has_in;
   entry_type           root_ff, root_in;
   logic                none_ff, none_in;
   logic                rej_ff, rej_in;
   entry_type           rd_q_ff;

   logic                wr_en;
   logic [NODE_W-1:0]   wr_addr;
   entry_type           wr_data;
   logic [NODE_W-1:0]   rd_addr;

   entry_type           cur;
   entry_type           link_entry;
   logic                bit_sel;
   logic                last;
   logic [NODE_W-1:0]   new_id;
   logic [NODE_W-1:0]   nxt_node;
   logic                pool_low;

   logic                out_load;
   logic                out_can_load;
   rsp_type             out_data;

   assign bit_sel  = key_ff[lvl_ff];
   assign last     = (lvl_ff == '0);
   assign new_id   = used_ff[NODE_W-1:0];
   assign pool_low = (used_ff > USED_LIMIT);
   assign cur      = (lvl_ff == LVL_TOP) ? root_ff : rd_q_ff;

   assign out_data.max_xor    = ans_ff;
   assign out_data.no_entries = none_ff;
   assign out_data.rejected   = rej_ff;

   always_comb begin
      state_in   = state_ff;
      lvl_in     = lvl_ff;
      node_in    = node_ff;
      key_in     = key_ff;
      kind_in    = kind_ff;
      ans_in     = ans_ff;
      used_in    = used_ff;
      has_in     = has_ff;
      root_in    = root_ff;
      none_in    = none_ff;
      rej_in     = rej_ff;
      wr_en      = 1'b0;
      wr_addr    = node_ff;
      wr_data    = cur;
      rd_addr    = node_ff;
      out_load   = 1'b0;
      req_ready  = 1'b0;
      link_entry = cur;
      nxt_node   = node_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in  = req_data.key;
               kind_in = req_data.kind;
               lvl_in  = LVL_TOP;
               node_in = '0;
               ans_in  = '0;
               none_in = 1'b0;
               rej_in  = 1'b0;
               if (req_data.kind == KIND_INSERT && pool_low) begin
                  rej_in   = 1'b1;
                  state_in = S_DONE;
               end else if (req_data.kind == KIND_QUERY && !has_ff) begin
                  none_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end

         S_WALK: begin
            if (kind_ff == KIND_QUERY || cur[bit_sel] != '0) begin
               // follow an existing link; a query prefers the opposite bit
               if (kind_ff == KIND_QUERY && cur[~bit_sel] != '0) begin
                  ans_in[lvl_ff] = 1'b1;
                  nxt_node       = cur[~bit_sel];
               end else if (cur[bit_sel] != '0) begin
                  nxt_node = cur[bit_sel];
               end
               rd_addr = nxt_node;
               node_in = nxt_node;
               if (last) begin
                  state_in = S_DONE;
               end else begin
                  lvl_in = lvl_ff - 1'b1;
               end
            end else begin
               // missing child: link a fresh node, the rest of the path is new
               link_entry[bit_sel] = new_id;
               if (lvl_ff == LVL_TOP) begin
                  root_in = link_entry;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = link_entry;
               end
               used_in = used_ff + CNT_W'(1);
               node_in = new_id;
               if (last) begin
                  state_in = S_DONE;
               end else begin
                  lvl_in   = lvl_ff - 1'b1;
                  state_in = S_FILL;
               end
            end
         end

         S_FILL: begin
            // node_ff was just allocated: its entry is cleared plus one link
            wr_en            = 1'b1;
            wr_data          = '0;
            wr_data[bit_sel] = new_id;
            used_in          = used_ff + CNT_W'(1);
            node_in          = new_id;
            if (last) begin
               state_in = S_DONE;
            end else begin
               lvl_in = lvl_ff - 1'b1;
            end
         end

         S_DONE: begin
            if (out_can_load) begin
               out_load = 1'b1;
               if (kind_ff == KIND_INSERT && !rej_ff) begin
                  has_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // write cycles never need read data, so one port serves both
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end else begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= CNT_W'(1);
         has_ff   <= 1'b0;
         root_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         has_ff   <= has_in;
         root_ff  <= root_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff  <= lvl_in;
      node_ff <= node_in;
      key_ff  <= key_in;
      kind_ff <= kind_in;
      ans_ff  <= ans_in;
      none_ff <= none_in;
      rej_ff  <= rej_in;
   end

   btmx_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (out_data),
      .can_load  (out_can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/tb_binary_trie_max_xor_core.sv
`timescale 1ns / 100ps

module tb_binary_trie_max_xor_core;
   import btmx_pkg::*;

   localparam int POOL_NODES  = 4096;
   localparam int LINK_W      = $clog2(POOL_NODES);
   localparam int RANDOM_WORDS = 1680;
   localparam int CYCLE_LIMIT = 600000;
   localparam int IDLE_PCT    = 22;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   binary_trie_max_xor_core #(
      .NODE_COUNT(POOL_NODES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow trie: link value 0 means no child, root is node 0
   logic [LINK_W-1:0] link0 [POOL_NODES];
   logic [LINK_W-1:0] link1 [POOL_NODES];
   int  nodes_used  = 1;
   bit  has_entries = 1'b0;

   req_type req_backlog [$];
   int      drain_marks [$];
   rsp_type pending_answers [$];
   logic [KEY_BITS-1:0] inserted_keys [$];
   logic [KEY_BITS-1:0] cluster_base [8];

   rsp_type oldest_answer;
   int  cycle_count   = 0;
   int  error_count   = 0;
   int  words_issued  = 0;
   int  words_sent    = 0;
   int  results_seen  = 0;
   int  total_words   = 0;
   int  n_insert      = 0;
   int  n_refused     = 0;
   int  n_query       = 0;
   int  n_empty       = 0;
   logic calm;

   // both sides stop idling for a while
   assign calm = (cycle_count >= 20000) && (cycle_count < 32000);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout: %0d of %0d words answered after %0d cycles",
                  results_seen, total_words, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic log_mismatch(string what);
      if (error_count < 30)
         $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic rsp_type trie_outcome(req_type w);
      rsp_type r;
      int  node;
      int  nxt;
      int  want;
      int  same;
      int  lvl;
      bit  b;
      r = '0;
      node = 0;
      if (w.kind == KIND_INSERT) begin
         n_insert++;
         if (POOL_NODES - nodes_used < KEY_BITS) begin
            r.rejected = 1'b1;
            n_refused++;
         end else begin
            for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
               b   = w.key[lvl];
               nxt = b ? int'(link1[node]) : int'(link0[node]);
               if (nxt == 0) begin
                  nxt = nodes_used;
                  link0[nxt] = '0;
                  link1[nxt] = '0;
                  nodes_used++;
                  if (b) link1[node] = LINK_W'(nxt);
                  else   link0[node] = LINK_W'(nxt);
               end
               node = nxt;
            end
            has_entries = 1'b1;
         end
      end else begin
         n_query++;
         if (!has_entries) begin
            r.no_entries = 1'b1;
            n_empty++;
         end else begin
            for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
               b    = w.key[lvl];
               want = b ? int'(link0[node]) : int'(link1[node]);
               same = b ? int'(link1[node]) : int'(link0[node]);
               if (want != 0) begin
                  r.max_xor[lvl] = 1'b1;
                  node = want;
               end else if (same != 0) begin
                  node = same;
               end
            end
         end
      end
      return r;
   endfunction

   task automatic queue_word(logic kind, logic [KEY_BITS-1:0] key);
      req_type w;
      w.kind = kind;
      w.key  = key;
      req_backlog.push_back(w);
      if (kind == KIND_INSERT)
         inserted_keys.push_back(key);
   endtask

   // early: mostly near a few cluster centers so the pool lasts;
   // late: wide keys and repeats, which fill the pool and hit rejection
   function automatic logic [KEY_BITS-1:0] pick_key(bit late);
      int roll;
      logic [KEY_BITS-1:0] spread;
      roll   = $urandom_range(0, 99);
      spread = {KEY_BITS{1'b1}} >> (KEY_BITS - $urandom_range(0, 12));
      if (roll < 3)
         return '0;
      if (roll < 6)
         return {KEY_BITS{1'b1}};
      if (late) begin
         if (roll < 45)
            return KEY_BITS'($urandom);
         if (roll < 75 && inserted_keys.size() != 0)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      end else begin
         if (roll < 10)
            return KEY_BITS'($urandom);
         if (roll < 18 && inserted_keys.size() != 0)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      end
      return cluster_base[$urandom_range(0, 7)] ^ (KEY_BITS'($urandom) & spread);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pending_answers.push_back(trie_outcome(req_data));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (drain_marks.size() != 0 && words_issued == drain_marks[0]
                && pending_answers.size() == 0)
               drain_marks.pop_front();
            if (req_backlog.size() != 0
                && !(drain_marks.size() != 0 && words_issued == drain_marks[0])
                && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
               words_issued++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_answers.size() == 0) begin
               log_mismatch("result word with nothing outstanding");
            end else begin
               oldest_answer = pending_answers.pop_front();
               if (rsp_data.max_xor !== oldest_answer.max_xor)
                  log_mismatch($sformatf("word %0d max_xor %h, want %h", results_seen,
                                         rsp_data.max_xor, oldest_answer.max_xor));
               if (rsp_data.no_entries !== oldest_answer.no_entries)
                  log_mismatch($sformatf("word %0d no_entries %b, want %b", results_seen,
                                         rsp_data.no_entries, oldest_answer.no_entries));
               if (rsp_data.rejected !== oldest_answer.rejected)
                  log_mismatch($sformatf("word %0d rejected %b, want %b", results_seen,
                                         rsp_data.rejected, oldest_answer.rejected));
            end
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      int  i;
      bit  late;
      logic kind;
      link0[0] = '0;
      link1[0] = '0;
      for (i = 0; i < 8; i++)
         cluster_base[i] = KEY_BITS'($urandom);

      // empty trie, extremes, duplicate, alternating and single-bit keys
      queue_word(KIND_QUERY,  '0);
      queue_word(KIND_QUERY,  {KEY_BITS{1'b1}});
      queue_word(KIND_INSERT, '0);
      queue_word(KIND_QUERY,  '0);
      queue_word(KIND_QUERY,  {KEY_BITS{1'b1}});
      queue_word(KIND_QUERY,  31'h5555_5555);
      queue_word(KIND_INSERT, {KEY_BITS{1'b1}});
      queue_word(KIND_INSERT, '0);
      queue_word(KIND_QUERY,  31'h2AAA_AAAA);
      queue_word(KIND_QUERY,  31'h4000_0000);
      queue_word(KIND_INSERT, 31'h2AAA_AAAA);
      queue_word(KIND_INSERT, 31'h5555_5555);
      queue_word(KIND_QUERY,  '0);
      queue_word(KIND_QUERY,  {KEY_BITS{1'b1}});
      queue_word(KIND_INSERT, 31'h4000_0000);
      queue_word(KIND_INSERT, 31'h0000_0001);
      queue_word(KIND_QUERY,  31'h0000_8000);
      queue_word(KIND_QUERY,  31'h2AAA_AAAA);
      drain_marks.push_back(req_backlog.size());

      for (i = 0; i < RANDOM_WORDS; i++) begin
         late = (i >= 900);
         if (i == 900 || i == 1300)
            drain_marks.push_back(req_backlog.size());
         kind = ($urandom_range(0, 99) < (late ? 50 : 55)) ? KIND_INSERT : KIND_QUERY;
         queue_word(kind, pick_key(late));
      end
      total_words = req_backlog.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (words_sent != total_words)
         @(posedge clock);
      while (pending_answers.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      if (pending_answers.size() != 0)
         log_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
      $display("covered %0d inserts (%0d refused on a full pool), %0d queries (%0d on empty trie)",
               n_insert, n_refused, n_query, n_empty);
      $display("pool nodes in use at end: %0d of %0d, mismatches: %0d",
               nodes_used, POOL_NODES, error_count);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
